// ===== hw/rtl/irc_pkg.sv =====
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types and constants for the ICMP reply classifier.
// ----------------------------------------------------------------------------
package irc_pkg;

  localparam logic [1:0] VERDICT_NONE          = 2'd0;
  localparam logic [1:0] VERDICT_TIME_EXCEEDED = 2'd1;
  localparam logic [1:0] VERDICT_UNREACH       = 2'd2;

  localparam logic [7:0] ICMP_TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] ICMP_TYPE_UNREACH       = 8'd3;
  localparam logic [7:0] IP_PROTO_UDP            = 8'd17;

  localparam logic [15:0] PROBE_IDENT_RESET = 16'h8000;
  localparam logic [15:0] BASE_PORT_RESET   = 16'd33434;

  // configuration register indexes
  localparam logic CFG_PROBE_IDENT = 1'b0;
  localparam logic CFG_BASE_PORT   = 1'b1;

  typedef struct packed {
    logic [15:0] probe_seq;
    logic        last_byte;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] unreach_code;
    logic [1:0] verdict;
  } result_t;

  typedef struct packed {
    logic [15:0] probe_ident;
    logic [15:0] base_port;
  } cfg_t;

endpackage

// ===== hw/rtl/icmp_reply_classifier.sv =====
// ----------------------------------------------------------------------------
// icmp_reply_classifier
// Classifies a received IPv4/ICMP packet as an answer to a UDP probe.
// ----------------------------------------------------------------------------
// usage:
//   the packet enters on the s_ stream one byte per item, s_tlast on its
//   final byte, with the expected probe sequence number beside each byte
//   (the one on the last byte is used). one verdict item leaves on the m_
//   stream per packet, none for the other bytes.
//   cfg_we/cfg_index/cfg_data write probe_ident (0) and base_port (1),
//   only while no packet is in flight.
// throughput: one byte per cycle unless a final byte waits (see stall), set by
//   the single capture stage between the input register and the result register.
// the verdict of the last byte is registered in the result register.
// reset: clears the byte counter and captures, empties both registers and
//   loads the register defaults; there is no clearing pass.
// stall: while m_tready is low non-final bytes keep flowing; a final byte
//   waits in the input register until the pending verdict is taken.
// bytes at positions MAX_PACKET and beyond are dropped from the count.
// ----------------------------------------------------------------------------
module icmp_reply_classifier #(
  parameter int MAX_PACKET = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], probe_seq[23:8]
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // verdict[1:0], unreach_code[9:2], zero[15:10]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  irc_pkg::item_t   s1_item;
  logic             s1_valid;
  irc_pkg::result_t out_res;
  logic             out_valid;
  irc_pkg::cfg_t    cfg;
  irc_pkg::result_t res_next;
  logic             adv;

  // a final byte needs the result register free, other bytes do not
  assign adv      = s1_valid && (!s1_item.last_byte || !out_valid || m_tready);
  assign s_tready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.probe_ident <= irc_pkg::PROBE_IDENT_RESET;
      cfg.base_port   <= irc_pkg::BASE_PORT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        irc_pkg::CFG_PROBE_IDENT: cfg.probe_ident <= cfg_data;
        irc_pkg::CFG_BASE_PORT:   cfg.base_port   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.data_byte <= s_tdata[7:0];
      s1_item.probe_seq <= s_tdata[23:8];
      s1_item.last_byte <= s_tlast;
    end
  end

  irc_field_capture #(
    .MAX_PACKET(MAX_PACKET)
  ) u_capture (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .item  (s1_item),
    .cfg   (cfg),
    .result(res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_item.last_byte) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.unreach_code, out_res.verdict};

endmodule

// ===== hw/rtl/irc_field_capture.sv =====
// ----------------------------------------------------------------------------
// irc_field_capture
// Per-packet byte counter and header field captures, with the verdict logic
// evaluated on the final byte of a packet.
// ----------------------------------------------------------------------------
module irc_field_capture #(
  parameter int MAX_PACKET = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  irc_pkg::item_t   item,
  input  irc_pkg::cfg_t    cfg,
  output irc_pkg::result_t result
);

  localparam int CW = $clog2(MAX_PACKET + 1);
  localparam int PW = (CW > 8) ? CW : 8;

  logic [CW-1:0] byte_count, byte_count_next;
  logic [5:0]    outer_hdr_len, outer_hdr_len_next;
  logic [7:0]    icmp_type, icmp_type_next;
  logic [7:0]    icmp_code, icmp_code_next;
  logic [5:0]    inner_hdr_len, inner_hdr_len_next;
  logic [7:0]    inner_protocol, inner_protocol_next;
  logic [15:0]   quoted_src_port, quoted_src_port_next;
  logic [15:0]   quoted_dst_port, quoted_dst_port_next;

  logic [PW-1:0] pos;
  logic [PW-1:0] inner_start;
  logic [PW-1:0] port_start;
  logic [PW-1:0] len;
  logic [PW-1:0] ohl_w;
  logic [15:0]   want_dst;
  logic          keep;
  logic          hdr_ok;
  logic          rest_ok;
  logic          is_tx;
  logic          is_un;
  logic          quote_ok;

  assign keep = byte_count < CW'(MAX_PACKET);
  assign pos  = PW'(byte_count);

  always_comb begin
    byte_count_next      = byte_count;
    outer_hdr_len_next   = outer_hdr_len;
    icmp_type_next       = icmp_type;
    icmp_code_next       = icmp_code;
    inner_hdr_len_next   = inner_hdr_len;
    inner_protocol_next  = inner_protocol;
    quoted_src_port_next = quoted_src_port;
    quoted_dst_port_next = quoted_dst_port;
    inner_start          = PW'(outer_hdr_len) + PW'(8);
    port_start           = inner_start + PW'(inner_hdr_len);
    if (keep) begin
      byte_count_next = byte_count + CW'(1);
      // a header length taken from this byte already applies to this byte
      if (pos == '0) begin
        outer_hdr_len_next = {item.data_byte[3:0], 2'b00};
      end
      if (pos == PW'(outer_hdr_len_next)) begin
        icmp_type_next = item.data_byte;
      end
      if (pos == PW'(outer_hdr_len_next) + PW'(1)) begin
        icmp_code_next = item.data_byte;
      end
      inner_start = PW'(outer_hdr_len_next) + PW'(8);
      if (pos == inner_start) begin
        inner_hdr_len_next = {item.data_byte[3:0], 2'b00};
      end
      if (pos == inner_start + PW'(9)) begin
        inner_protocol_next = item.data_byte;
      end
      port_start = inner_start + PW'(inner_hdr_len_next);
      if (pos == port_start) begin
        quoted_src_port_next[15:8] = item.data_byte;
      end
      if (pos == port_start + PW'(1)) begin
        quoted_src_port_next[7:0] = item.data_byte;
      end
      if (pos == port_start + PW'(2)) begin
        quoted_dst_port_next[15:8] = item.data_byte;
      end
      if (pos == port_start + PW'(3)) begin
        quoted_dst_port_next[7:0] = item.data_byte;
      end
    end
  end

  // verdict from the updated captures
  assign len      = PW'(byte_count_next);
  assign ohl_w    = PW'(outer_hdr_len_next);
  assign want_dst = cfg.base_port + item.probe_seq;
  assign hdr_ok   = len >= ohl_w + PW'(8);
  // only meaningful when hdr_ok, so the subtraction cannot wrap
  assign rest_ok  = (PW'(inner_hdr_len_next) + PW'(12)) <= (len - ohl_w);
  assign is_tx    = (icmp_type_next == irc_pkg::ICMP_TYPE_TIME_EXCEEDED) &&
                    (icmp_code_next == 8'd0);
  assign is_un    = icmp_type_next == irc_pkg::ICMP_TYPE_UNREACH;
  assign quote_ok = rest_ok && (inner_protocol_next == irc_pkg::IP_PROTO_UDP) &&
                    (quoted_src_port_next == cfg.probe_ident) &&
                    (quoted_dst_port_next == want_dst);

  always_comb begin
    result.verdict      = irc_pkg::VERDICT_NONE;
    result.unreach_code = 8'd0;
    if (hdr_ok && quote_ok) begin
      if (is_tx) begin
        result.verdict = irc_pkg::VERDICT_TIME_EXCEEDED;
      end else if (is_un) begin
        result.verdict      = irc_pkg::VERDICT_UNREACH;
        result.unreach_code = icmp_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (en && item.last_byte)) begin
      byte_count      <= '0;
      outer_hdr_len   <= '0;
      icmp_type       <= '0;
      icmp_code       <= '0;
      inner_hdr_len   <= '0;
      inner_protocol  <= '0;
      quoted_src_port <= '0;
      quoted_dst_port <= '0;
    end else if (en) begin
      byte_count      <= byte_count_next;
      outer_hdr_len   <= outer_hdr_len_next;
      icmp_type       <= icmp_type_next;
      icmp_code       <= icmp_code_next;
      inner_hdr_len   <= inner_hdr_len_next;
      inner_protocol  <= inner_protocol_next;
      quoted_src_port <= quoted_src_port_next;
      quoted_dst_port <= quoted_dst_port_next;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for icmp_reply_classifier: sends ICMP reply packets
// byte by byte, predicts each per-packet verdict and compares it with the
// m_ stream under random source and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import irc_pkg::*;

  localparam int MAX_PACKET  = 512;
  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_PROBE_IDENT;
  logic [15:0] cfg_data = '0;

  icmp_reply_classifier #(.MAX_PACKET(MAX_PACKET)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // shadow registers and per-packet capture state of the classifier
  logic [15:0] want_ident = PROBE_IDENT_RESET;
  logic [15:0] want_base  = BASE_PORT_RESET;
  int          kept_bytes;
  int          outer_len;
  logic [7:0]  reply_type;
  logic [7:0]  reply_code;
  int          quoted_len;
  logic [7:0]  quoted_proto;
  logic [15:0] quoted_sport;
  logic [15:0] quoted_dport;

  result_t     verdicts_due[$];
  result_t     next_due;
  logic [7:0]  byte_buf[$];

  int send_gap_pct;
  int take_gap_pct;
  int errors;
  int packets_sent;
  int bytes_sent;
  int seen_none;
  int seen_tx;
  int seen_unreach;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic clear_capture();
    kept_bytes   = 0;
    outer_len    = 0;
    reply_type   = '0;
    reply_code   = '0;
    quoted_len   = 0;
    quoted_proto = '0;
    quoted_sport = '0;
    quoted_dport = '0;
  endtask

  // captures one accepted byte; on the final byte queues the verdict
  task automatic absorb_byte(input logic [7:0] b, input logic last,
                             input logic [15:0] seq);
    int          inner_at;
    int          ports_at;
    bit          is_tx;
    bit          is_un;
    logic [15:0] want_dport;
    result_t     res;
    if (kept_bytes < MAX_PACKET) begin
      // a header length takes effect for the byte that carries it
      if (kept_bytes == 0) outer_len = int'(b[3:0]) * 4;
      if (kept_bytes == outer_len) reply_type = b;
      if (kept_bytes == outer_len + 1) reply_code = b;
      inner_at = outer_len + 8;
      if (kept_bytes == inner_at) quoted_len = int'(b[3:0]) * 4;
      if (kept_bytes == inner_at + 9) quoted_proto = b;
      ports_at = inner_at + quoted_len;
      if (kept_bytes == ports_at) quoted_sport[15:8] = b;
      if (kept_bytes == ports_at + 1) quoted_sport[7:0] = b;
      if (kept_bytes == ports_at + 2) quoted_dport[15:8] = b;
      if (kept_bytes == ports_at + 3) quoted_dport[7:0] = b;
      kept_bytes++;
    end
    if (last) begin
      res = '0;
      res.verdict = VERDICT_NONE;
      if (kept_bytes >= outer_len + 8) begin
        is_tx = (reply_type == ICMP_TYPE_TIME_EXCEEDED) && (reply_code == 8'd0);
        is_un = (reply_type == ICMP_TYPE_UNREACH);
        want_dport = want_base + seq;
        if ((is_tx || is_un) && (quoted_len + 12 <= kept_bytes - outer_len) &&
            quoted_proto == IP_PROTO_UDP && quoted_sport == want_ident &&
            quoted_dport == want_dport) begin
          if (is_tx) begin
            res.verdict = VERDICT_TIME_EXCEEDED;
          end else begin
            res.verdict      = VERDICT_UNREACH;
            res.unreach_code = reply_code;
          end
        end
      end
      verdicts_due.push_back(res);
      clear_capture();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic [15:0] seq);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {seq, b};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_byte(b, last, seq);
    bytes_sent++;
  endtask

  // the sequence number on the final byte is the one that counts
  task automatic send_packet(input logic [15:0] seq);
    int i;
    for (i = 0; i < byte_buf.size(); i++) begin
      if (i == byte_buf.size() - 1) send_byte(byte_buf[i], 1'b1, seq);
      else send_byte(byte_buf[i], 1'b0, 16'($urandom));
    end
    packets_sent++;
  endtask

  function automatic void put_byte(input int idx, input logic [7:0] v);
    if (idx < byte_buf.size()) byte_buf[idx] = v;
  endfunction

  // lays out outer header, icmp header, quoted header and udp ports over
  // random filler; cut > 0 truncates the packet to that many bytes
  task automatic build_reply(input int ohl, input logic [7:0] typ,
                             input logic [7:0] code, input int ihl,
                             input logic [7:0] proto, input logic [15:0] sport,
                             input logic [15:0] dport, input int cut);
    int h;
    int inner_at;
    int ports_at;
    int len;
    h        = ohl * 4;
    inner_at = h + 8;
    ports_at = inner_at + ihl * 4;
    len      = (cut > 0) ? cut : ports_at + 4 + $urandom_range(6);
    byte_buf.delete();
    repeat (len) byte_buf.push_back(8'($urandom));
    put_byte(0, {4'($urandom), 4'(ohl)});
    put_byte(h, typ);
    put_byte(h + 1, code);
    put_byte(inner_at, {4'($urandom), 4'(ihl)});
    put_byte(inner_at + 9, proto);
    put_byte(ports_at, sport[15:8]);
    put_byte(ports_at + 1, sport[7:0]);
    put_byte(ports_at + 2, dport[15:8]);
    put_byte(ports_at + 3, dport[7:0]);
  endtask

  // stop sending, let every verdict drain, then a few spare cycles
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_PROBE_IDENT) want_ident = val;
    else want_base = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    build_reply(5, ICMP_TYPE_TIME_EXCEEDED, 8'd0, 5, IP_PROTO_UDP, want_ident,
                want_base, 0);
    send_packet(16'h0000);
    // destination port wraps past 65535
    build_reply(5, ICMP_TYPE_UNREACH, 8'd3, 5, IP_PROTO_UDP, want_ident,
                want_base + 16'hffff, 0);
    send_packet(16'hffff);
  endtask

  task automatic test_short_packets();
    byte_buf = '{8'h00};
    send_packet(16'h0000);
    byte_buf = '{8'hff};
    send_packet(16'hffff);
    byte_buf = '{8'h45, 8'h00};
    send_packet(16'($urandom));
  endtask

  task automatic test_verdict_kinds();
    logic [15:0] seq;
    seq = 16'($urandom);
    build_reply(5, ICMP_TYPE_UNREACH, 8'hff, 5, IP_PROTO_UDP, want_ident,
                want_base + seq, 0);
    send_packet(seq);
    build_reply(6, ICMP_TYPE_UNREACH, 8'h00, 15, IP_PROTO_UDP, want_ident,
                want_base + seq, 0);
    send_packet(seq);
    // time exceeded with a nonzero code is not ours
    build_reply(5, ICMP_TYPE_TIME_EXCEEDED, 8'd1, 5, IP_PROTO_UDP, want_ident,
                want_base + seq, 0);
    send_packet(seq);
    build_reply(5, ICMP_TYPE_TIME_EXCEEDED, 8'd0, 5, 8'd6, want_ident,
                want_base + seq, 0);
    send_packet(seq);
    build_reply(5, ICMP_TYPE_UNREACH, 8'd1, 5, IP_PROTO_UDP, ~want_ident,
                want_base + seq, 0);
    send_packet(seq);
    build_reply(5, ICMP_TYPE_UNREACH, 8'd1, 5, IP_PROTO_UDP, want_ident,
                want_base + seq + 16'd1, 0);
    send_packet(seq);
    // truncated: icmp header incomplete, then last port byte missing
    build_reply(5, ICMP_TYPE_TIME_EXCEEDED, 8'd0, 5, IP_PROTO_UDP, want_ident,
                want_base + seq, 27);
    send_packet(seq);
    build_reply(5, ICMP_TYPE_TIME_EXCEEDED, 8'd0, 5, IP_PROTO_UDP, want_ident,
                want_base + seq, 51);
    send_packet(seq);
  endtask

  // header lengths so small that fields share byte positions
  task automatic test_overlap();
    int ohl_set[5];
    int ihl_set[5];
    int i;
    logic [15:0] seq;
    ohl_set = '{0, 1, 2, 3, 4};
    ihl_set = '{0, 0, 1, 2, 0};
    for (i = 0; i < 5; i++) begin
      seq = 16'($urandom);
      build_reply(ohl_set[i], $urandom_range(1) ? ICMP_TYPE_UNREACH
                  : ICMP_TYPE_TIME_EXCEEDED, 8'd0, ihl_set[i], IP_PROTO_UDP,
                  want_ident, want_base + seq, 0);
      send_packet(seq);
    end
  endtask

  // bytes from position MAX_PACKET on are dropped
  task automatic test_oversize();
    int lens[3];
    int i;
    logic [15:0] seq;
    lens = '{MAX_PACKET, MAX_PACKET + 1, MAX_PACKET + 18};
    for (i = 0; i < 3; i++) begin
      seq = 16'($urandom);
      build_reply(5, ICMP_TYPE_UNREACH, 8'($urandom), 5, IP_PROTO_UDP,
                  want_ident, want_base + seq, 0);
      while (byte_buf.size() < lens[i]) byte_buf.push_back(8'($urandom));
      send_packet(seq);
    end
  endtask

  task automatic test_config_extremes();
    drain();
    write_reg(CFG_PROBE_IDENT, 16'h0000);
    write_reg(CFG_BASE_PORT, 16'hffff);
    build_reply(5, ICMP_TYPE_TIME_EXCEEDED, 8'd0, 5, IP_PROTO_UDP, 16'h0000,
                16'h0000, 0);
    send_packet(16'h0001);
    drain();
    write_reg(CFG_PROBE_IDENT, 16'hffff);
    write_reg(CFG_BASE_PORT, 16'h0000);
    build_reply(5, ICMP_TYPE_UNREACH, 8'd10, 5, IP_PROTO_UDP, 16'hffff,
                16'hffff, 0);
    send_packet(16'hffff);
  endtask

  task automatic random_reply();
    int          ohl;
    int          ihl;
    int          r;
    int          natural_len;
    logic [7:0]  typ;
    logic [7:0]  code;
    logic [15:0] seq;
    r   = $urandom_range(99);
    seq = 16'($urandom);
    if (r < 80) begin
      ohl = $urandom_range(1) ? 5 : $urandom_range(15);
      ihl = $urandom_range(1) ? 5 : $urandom_range(15);
      r   = $urandom_range(99);
      typ = (r < 45) ? ICMP_TYPE_TIME_EXCEEDED : (r < 90) ? ICMP_TYPE_UNREACH
            : 8'($urandom);
      if (typ == ICMP_TYPE_TIME_EXCEEDED && $urandom_range(9) != 0) code = 8'd0;
      else code = 8'($urandom);
      natural_len = 0;
      if ($urandom_range(99) < 15) natural_len = $urandom_range(1, ohl*4 + ihl*4 + 12);
      build_reply(ohl, typ, code, ihl,
                  ($urandom_range(9) != 0) ? IP_PROTO_UDP : 8'($urandom),
                  ($urandom_range(9) != 0) ? want_ident : 16'($urandom),
                  ($urandom_range(9) != 0) ? 16'(want_base + seq) : 16'($urandom),
                  natural_len);
    end else begin
      byte_buf.delete();
      repeat ($urandom_range(1, 24)) byte_buf.push_back(8'($urandom));
    end
    send_packet(seq);
  endtask

  task automatic test_random(input int send_pct, input int take_pct);
    int start_bytes;
    int start_packets;
    drain();
    write_reg(CFG_PROBE_IDENT, 16'($urandom));
    write_reg(CFG_BASE_PORT, 16'($urandom));
    send_gap_pct  = send_pct;
    take_gap_pct  = take_pct;
    start_bytes   = bytes_sent;
    start_packets = packets_sent;
    while (bytes_sent - start_bytes < 200 || packets_sent - start_packets < 15)
      random_reply();
  endtask

  // verdict checker and sink stalls
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict with none pending", m_tdata, 16'h0000);
      end else begin
        next_due = verdicts_due.pop_front();
        if (m_tdata[1:0] != next_due.verdict)
          report_mismatch("verdict", 16'(m_tdata[1:0]), 16'(next_due.verdict));
        if (m_tdata[9:2] != next_due.unreach_code)
          report_mismatch("unreach_code", 16'(m_tdata[9:2]),
                          16'(next_due.unreach_code));
        if (m_tdata[15:10] != 6'd0)
          report_mismatch("tdata padding", 16'(m_tdata[15:10]), 16'h0000);
        case (m_tdata[1:0])
          VERDICT_TIME_EXCEEDED: seen_tx++;
          VERDICT_UNREACH:       seen_unreach++;
          default:               seen_none++;
        endcase
      end
    end
    m_tready <= ($urandom_range(99) >= take_gap_pct);
  end

  // watchdog: cycles in a row with no item moving on either stream
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled = 0;
      else stalled++;
    end
    $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    send_gap_pct = 29;
    take_gap_pct = 87;
    clear_capture();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_short_packets();
    test_verdict_kinds();
    test_overlap();
    test_oversize();
    test_config_extremes();
    test_random(29, 87);
    test_random(87, 29);
    test_random(0, 0);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d packets, %0d bytes, incl. truncated, overlapping and oversize",
             packets_sent, bytes_sent);
    $display("verdicts: %0d no match, %0d time exceeded, %0d unreachable",
             seen_none, seen_tx, seen_unreach);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
